// ===== rtl/assert_macros.svh =====
// Assertion helpers, included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, quiet during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/sib_pkg.sv =====
`default_nettype none

package sib_pkg;

  localparam int unsigned SIB_DEPTH      = 16;
  localparam int unsigned SIB_VALUE_BITS = 32;

  localparam int unsigned STATUS_BITS = 3;
  localparam int unsigned COUNT_BITS  = 5;
  localparam int unsigned AMODE_BITS  = 3;
  localparam int unsigned CAP_BITS    = 5;
  localparam int unsigned CFG_BITS    = 5;
  localparam int unsigned OP_BITS     = 2;

  // Input item codes
  localparam logic [OP_BITS-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_BITS-1:0] OP_READ   = 2'd1;
  localparam logic [OP_BITS-1:0] OP_CLEAR  = 2'd2;

  // Result status codes
  localparam logic [STATUS_BITS-1:0] ST_INSERTED   = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_FILTERED   = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL       = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_READ_ENTRY = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_READ_EMPTY = 3'd4;
  localparam logic [STATUS_BITS-1:0] ST_CLEARED    = 3'd5;

  // Placement modes
  localparam logic [AMODE_BITS-1:0] AM_APPEND   = 3'd0;
  localparam logic [AMODE_BITS-1:0] AM_FRONT    = 3'd1;
  localparam logic [AMODE_BITS-1:0] AM_SORTED   = 3'd2;
  localparam logic [AMODE_BITS-1:0] AM_SORT_POS = 3'd3;
  localparam logic [AMODE_BITS-1:0] AM_SORT_NEG = 3'd4;

  // Register indexes
  localparam logic REG_ARRAY_MODE = 1'b0;
  localparam logic REG_CAPACITY   = 1'b1;

  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

  typedef struct packed {
    logic insert;
    logic clear;
    logic read_start;
    logic read_beat;
  } sib_cmd_t;

  typedef struct packed {
    logic empty;
    logic cnt_one;
    logic rem_one;
  } sib_stat_t;

endpackage

`default_nettype wire

// ===== rtl/sib_datapath.sv =====
`default_nettype none

module sib_datapath #(
  parameter int unsigned DEPTH      = sib_pkg::SIB_DEPTH,
  parameter int unsigned VALUE_BITS = sib_pkg::SIB_VALUE_BITS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic                                  cfg_idx_i,
  input  logic [sib_pkg::CFG_BITS-1:0]          cfg_wdata_i,
  input  logic signed [VALUE_BITS-1:0]          value_i,
  input  sib_pkg::sib_cmd_t                     cmd_i,
  output sib_pkg::sib_stat_t                    stat_o,
  output logic                                  result_strobe_o,
  output logic [sib_pkg::STATUS_BITS-1:0]       status_o,
  output logic signed [VALUE_BITS-1:0]          entry_value_o,
  output logic [sib_pkg::COUNT_BITS-1:0]        entry_count_o,
  output logic                                  is_last_o
);
  import sib_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > COUNT_BITS) ? CNT_W : COUNT_BITS;

  logic signed [VALUE_BITS-1:0] cell_q [DEPTH];
  logic signed [VALUE_BITS-1:0] cell_d [DEPTH];
  logic signed [VALUE_BITS-1:0] prev_val [DEPTH];
  logic signed [VALUE_BITS-1:0] next_val [DEPTH];

  logic [CNT_W-1:0]      count_q, count_d;
  logic [CNT_W-1:0]      rem_q, rem_d;
  logic [AMODE_BITS-1:0] array_mode_q;
  logic [CAP_BITS-1:0]   capacity_q;

  logic [DEPTH-1:0] ge, shift_up;
  logic             sorted, front, neg, filtered, full, do_insert, do_rot;

  logic                         strobe_q, strobe_d;
  logic [STATUS_BITS-1:0]       res_status_q, res_status_d;
  logic signed [VALUE_BITS-1:0] res_value_q, res_value_d;
  logic                         res_last_q, res_last_d;
  logic [CMP_W-1:0]             cnt_ext;
  logic [COUNT_BITS-1:0]        res_count_q;

  // Neighbor taps of the cell row
  for (genvar g = 0; g < DEPTH; g++) begin : g_tap
    if (g == 0) begin : g_first
      assign prev_val[g] = cell_q[g];
    end else begin : g_prev
      assign prev_val[g] = cell_q[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign next_val[g] = cell_q[g];
    end else begin : g_next
      assign next_val[g] = cell_q[g+1];
    end
  end

  always_comb begin
    sorted   = (array_mode_q == AM_SORTED) || (array_mode_q == AM_SORT_POS) ||
               (array_mode_q == AM_SORT_NEG);
    front    = (array_mode_q == AM_FRONT);
    neg      = value_i[VALUE_BITS-1];
    filtered = ((array_mode_q == AM_SORT_POS) && (neg || (value_i == '0))) ||
               ((array_mode_q == AM_SORT_NEG) && !neg);
    full     = (CMP_W'(count_q) >= CMP_W'(capacity_q)) || (count_q == CNT_W'(DEPTH));
    do_insert = cmd_i.insert && !filtered && !full;
    do_rot    = (cmd_i.read_start && (count_q != '0)) || cmd_i.read_beat;

    // Each occupied cell flags whether the new value goes at or ahead of it
    for (int i = 0; i < DEPTH; i++) begin
      ge[i] = (CNT_W'(i) < count_q) &&
              (front ? (i == 0) : (sorted && (cell_q[i] >= value_i)));
    end
    // A cell shifts up when some lower cell already took the insert point
    for (int i = 0; i < DEPTH; i++) begin
      shift_up[i] = |(ge & ((DEPTH'(1) << i) - DEPTH'(1)));
    end

    for (int i = 0; i < DEPTH; i++) begin
      cell_d[i] = cell_q[i];
      if (do_insert) begin
        if (!shift_up[i] && (ge[i] || (CNT_W'(i) == count_q))) begin
          cell_d[i] = value_i;
        end else if (shift_up[i] && (CNT_W'(i) <= count_q)) begin
          cell_d[i] = prev_val[i];
        end
      end else if (do_rot) begin
        // rotate the occupied cells down by one beat
        if (CNT_W'(i + 1) < count_q) begin
          cell_d[i] = next_val[i];
        end else if (CNT_W'(i + 1) == count_q) begin
          cell_d[i] = cell_q[0];
        end
      end
    end
  end

  always_comb begin
    count_d      = count_q;
    rem_d        = rem_q;
    strobe_d     = 1'b0;
    res_status_d = res_status_q;
    res_value_d  = '0;
    res_last_d   = 1'b1;
    if (cmd_i.insert) begin
      strobe_d = 1'b1;
      priority if (filtered) begin
        res_status_d = ST_FILTERED;
      end else if (full) begin
        res_status_d = ST_FULL;
      end else begin
        res_status_d = ST_INSERTED;
        count_d      = count_q + CNT_W'(1);
      end
    end else if (cmd_i.clear) begin
      strobe_d     = 1'b1;
      res_status_d = ST_CLEARED;
      count_d      = '0;
    end else if (cmd_i.read_start) begin
      strobe_d = 1'b1;
      if (count_q == '0) begin
        res_status_d = ST_READ_EMPTY;
      end else begin
        res_status_d = ST_READ_ENTRY;
        res_value_d  = cell_q[0];
        res_last_d   = (count_q == CNT_W'(1));
        rem_d        = count_q - CNT_W'(1);
      end
    end else if (cmd_i.read_beat) begin
      strobe_d     = 1'b1;
      res_status_d = ST_READ_ENTRY;
      res_value_d  = cell_q[0];
      res_last_d   = (rem_q == CNT_W'(1));
      rem_d        = rem_q - CNT_W'(1);
    end
    cnt_ext = CMP_W'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      rem_q        <= '0;
      strobe_q     <= 1'b0;
      array_mode_q <= AM_APPEND;
      capacity_q   <= CAP_RESET;
    end else begin
      count_q  <= count_d;
      rem_q    <= rem_d;
      strobe_q <= strobe_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_ARRAY_MODE: array_mode_q <= cfg_wdata_i[AMODE_BITS-1:0];
          REG_CAPACITY:   capacity_q   <= cfg_wdata_i[CAP_BITS-1:0];
          default:        capacity_q   <= capacity_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q       <= cell_d;
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
    res_last_q   <= res_last_d;
    res_count_q  <= cnt_ext[COUNT_BITS-1:0];
  end

  assign stat_o.empty   = (count_q == '0);
  assign stat_o.cnt_one = (count_q == CNT_W'(1));
  assign stat_o.rem_one = (rem_q == CNT_W'(1));

  assign result_strobe_o = strobe_q;
  assign status_o        = res_status_q;
  assign entry_value_o   = res_value_q;
  assign entry_count_o   = res_count_q;
  assign is_last_o       = res_last_q;

endmodule

`default_nettype wire

// ===== rtl/sib_ctrl.sv =====
`default_nettype none

module sib_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  input  logic [sib_pkg::OP_BITS-1:0]   mode_i,
  input  sib_pkg::sib_stat_t            stat_i,
  output sib_pkg::sib_cmd_t             cmd_o,
  output logic                          busy
);
  import sib_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_e;

  state_e state_q;
  logic   busy_q;

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          unique case (mode_i)
            OP_INSERT: cmd_o.insert = 1'b1;
            OP_CLEAR:  cmd_o.clear  = 1'b1;
            default:   cmd_o.read_start = 1'b1;
          endcase
        end
      end
      S_READ: cmd_o.read_beat = 1'b1;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          // stay in place for a single-beat readout
          if (cmd_o.read_start && !stat_i.empty && !stat_i.cnt_one) begin
            state_q <= S_READ;
            busy_q  <= 1'b1;
          end
        end
        S_READ: begin
          if (stat_i.rem_one) begin
            state_q <= S_IDLE;
            busy_q  <= 1'b0;
          end
        end
        default: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

  assign busy = busy_q;

endmodule

`default_nettype wire

// ===== rtl/sorted_insertion_buffer_unit.sv =====
`default_nettype none

// Buffer of up to DEPTH signed fixed-point values, kept in a row of registers.
// An insert, a clear or a readout of an empty buffer gives a single beat: it
// shows on the result ports in the cycle after start, and busy stays low,
// so a new item may start in that same cycle. A readout of N stored
// entries gives N beats on consecutive cycles, the first in the cycle after
// start, and holds busy high while the remaining beats are issued; the row
// of cells rotates by one place per cycle to present each entry. The result
// strobe is high for exactly one cycle per beat and the receiver cannot
// stall it, so every beat must be taken when it shows. Storage needs no
// clearing pass after reset.
module sorted_insertion_buffer_unit #(
  parameter int unsigned DEPTH      = sib_pkg::SIB_DEPTH,
  parameter int unsigned VALUE_BITS = sib_pkg::SIB_VALUE_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic                             cfg_idx_i,
  input  logic [sib_pkg::CFG_BITS-1:0]     cfg_wdata_i,
  input  logic                             start,
  output logic                             busy,
  input  logic [sib_pkg::OP_BITS-1:0]      mode_i,
  input  logic signed [VALUE_BITS-1:0]     value_i,
  output logic                             result_strobe_o,
  output logic [sib_pkg::STATUS_BITS-1:0]  status_o,
  output logic signed [VALUE_BITS-1:0]     entry_value_o,
  output logic [sib_pkg::COUNT_BITS-1:0]   entry_count_o,
  output logic                             is_last_o
);
  import sib_pkg::*;

  sib_cmd_t  cmd;
  sib_stat_t stat;

  sib_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .mode_i (mode_i),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  sib_datapath #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .value_i         (value_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .result_strobe_o (result_strobe_o),
    .status_o        (status_o),
    .entry_value_o   (entry_value_o),
    .entry_count_o   (entry_count_o),
    .is_last_o       (is_last_o)
  );

`include "assert_macros.svh"

  // While streaming, every cycle carries a beat that is not the final one
  `ASSERT_IMPLIES(a_busy_streams, clk_i, rst_ni, busy, result_strobe_o && !is_last_o, "readout beat missing while busy")

  // Insert and clear answer with one final beat in the next cycle
  `ASSERT_NEXT(a_single_beat, clk_i, rst_ni, start && !busy && ((mode_i == OP_INSERT) || (mode_i == OP_CLEAR)), result_strobe_o && is_last_o, "single-beat result missing")

  // Only readout entries carry a stored value
  `ASSERT_IMPLIES(a_value_zero, clk_i, rst_ni, result_strobe_o && (status_o != ST_READ_ENTRY), entry_value_o == '0, "nonzero value outside readout")

  // Controller never issues two commands at once
  `ASSERT_IMPLIES(a_cmd_onehot, clk_i, rst_ni, 1'b1, $onehot0(cmd), "conflicting datapath commands")

endmodule

`default_nettype wire
